// ----- rtl/core/cit_pkg.sv -----
// shared types and constants for the card id set table
`default_nettype none
package cit_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_CLR = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_PRESENT = 2'd1,
    STS_FULL    = 2'd2,
    STS_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/card_id_set_table.sv -----
// top level of the card id set table: control and a row of compacting cells
// result strobe out_valid is registered; an accepted item passes ST_CMP, then ST_EXEC
// items are taken one at a time (capture, registered compare in all cells, update)
// busy is high from the accept edge until the result strobe; results cannot be stalled
// reset: synchronous active-low rst_n empties the list; cell contents are not cleared
`default_nettype none
module card_id_set_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [cit_pkg::ID_W-1:0]  in_card_id,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [cit_pkg::CNT_W-1:0]      out_stored_count
);

  cit_pkg::state_t           state_r, state_nxt;
  cit_pkg::op_t              op_r;
  logic [cit_pkg::ID_W-1:0]  id_r;
  logic [cit_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  cit_pkg::status_t          out_status_r, status_nxt;

  cit_pkg::cell_ctl_t        ctl     [cit_pkg::TABLE_DEPTH];
  logic [cit_pkg::ID_W-1:0]  cell_id [cit_pkg::TABLE_DEPTH];
  logic [cit_pkg::TABLE_DEPTH-1:0] match_vec;
  logic [cit_pkg::TABLE_DEPTH-1:0] valid_vec;
  logic [cit_pkg::TABLE_DEPTH-1:0] hit_vec;
  logic [cit_pkg::TABLE_DEPTH-1:0] after_hit;
  logic                      hit;
  logic                      full;

  // row of cells
  for (genvar g = 0; g < cit_pkg::TABLE_DEPTH; g++) begin : g_cell
    logic [cit_pkg::ID_W-1:0] nbr_id;
    if (g == cit_pkg::TABLE_DEPTH - 1) begin : g_last
      assign nbr_id = cell_id[g];
    end else begin : g_mid
      assign nbr_id = cell_id[g+1];
    end
    cit_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .in_id   (id_r),
      .next_id (nbr_id),
      .id_q    (cell_id[g]),
      .match   (match_vec[g])
    );
  end

  always_comb begin
    for (int i = 0; i < cit_pkg::TABLE_DEPTH; i++) begin
      valid_vec[i] = (count_r > cit_pkg::CNT_W'(i));
    end
    hit_vec = match_vec & valid_vec;
    hit     = |hit_vec;
    full    = (count_r == cit_pkg::CNT_W'(cit_pkg::TABLE_DEPTH));
    // cells at or above the matching entry take their upper neighbor
    for (int i = 0; i < cit_pkg::TABLE_DEPTH; i++) begin
      after_hit[i] = |(hit_vec & cit_pkg::TABLE_DEPTH'(
        ((cit_pkg::TABLE_DEPTH + 1)'(1) << (i + 1)) - (cit_pkg::TABLE_DEPTH + 1)'(1)));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cit_pkg::ST_IDLE: if (start) state_nxt = cit_pkg::ST_CMP;
      cit_pkg::ST_CMP:  state_nxt = cit_pkg::ST_EXEC;
      cit_pkg::ST_EXEC: state_nxt = cit_pkg::ST_IDLE;
      default:          state_nxt = cit_pkg::ST_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = cit_pkg::STS_DONE;
    out_valid_nxt = 1'b0;
    for (int i = 0; i < cit_pkg::TABLE_DEPTH; i++) begin
      ctl[i] = '0;
    end
    unique case (state_r)
      cit_pkg::ST_EXEC: begin
        out_valid_nxt = 1'b1;
        unique case (op_r)
          cit_pkg::OP_ADD: begin
            if (hit) begin
              status_nxt = cit_pkg::STS_PRESENT;
            end else if (full) begin
              status_nxt = cit_pkg::STS_FULL;
            end else begin
              for (int i = 0; i < cit_pkg::TABLE_DEPTH; i++) begin
                ctl[i].wr_en = (count_r[cit_pkg::IDX_W-1:0] == cit_pkg::IDX_W'(i));
              end
              count_nxt = count_r + cit_pkg::CNT_W'(1);
            end
          end
          cit_pkg::OP_DEL: begin
            if (!hit) begin
              status_nxt = cit_pkg::STS_MISSING;
            end else begin
              for (int i = 0; i < cit_pkg::TABLE_DEPTH - 1; i++) begin
                ctl[i].shift_en = after_hit[i];
              end
              count_nxt = count_r - cit_pkg::CNT_W'(1);
            end
          end
          cit_pkg::OP_CLR: count_nxt = '0;
          cit_pkg::OP_NOP: count_nxt = count_r;
          default:         count_nxt = count_r;
        endcase
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cit_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cit_pkg::ST_IDLE && start) begin
      op_r <= cit_pkg::op_t'(in_opcode);
      id_r <= in_card_id;
    end
    if (state_r == cit_pkg::ST_EXEC) begin
      out_status_r <= status_nxt;
    end
  end

  assign busy             = (state_r != cit_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_stored_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cit_pkg::CNT_W'(cit_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == cit_pkg::ST_EXEC) && !busy)
    else $error("result strobe outside its slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 out_valid)
    else $error("item did not finish in three cycles");

  a_no_wr_on_del: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cit_pkg::ST_EXEC && op_r == cit_pkg::OP_DEL) |->
      !(ctl[0].wr_en) && (count_nxt <= count_r))
    else $error("delete wrote a cell or grew the list");

endmodule
`default_nettype wire

// ----- rtl/core/cit_cell.sv -----
// one table cell: holds an id, compares it, takes its upper neighbor on a shift
`default_nettype none
module cit_cell (
  input  wire logic                   clk,
  input  wire cit_pkg::cell_ctl_t     ctl,
  input  wire logic [cit_pkg::ID_W-1:0] in_id,
  input  wire logic [cit_pkg::ID_W-1:0] next_id,
  output logic [cit_pkg::ID_W-1:0]    id_q,
  output logic                        match
);

  logic [cit_pkg::ID_W-1:0] id_r;
  logic                     match_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      id_r <= in_id;
    end else if (ctl.shift_en) begin
      id_r <= next_id;
    end
    match_r <= (id_r == in_id);
  end

  assign id_q  = id_r;
  assign match = match_r;

endmodule
`default_nettype wire
